/* sv/ci64_pkg.sv */
// Shared types, codes and a helper function for the checked 64-bit ALU.
package ci64_pkg;

    localparam int DataW     = 64;
    localparam int HalfW     = 32;
    localparam int DivStages = 64;
    localparam int MulStages = 3;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MOD  = 4'd4;
    localparam logic [3:0] OP_SHL  = 4'd5;
    localparam logic [3:0] OP_SHR  = 4'd6;
    localparam logic [3:0] OP_AND  = 4'd7;
    localparam logic [3:0] OP_XOR  = 4'd8;
    localparam logic [3:0] OP_OR   = 4'd9;
    localparam logic [3:0] OP_NEG  = 4'd10;
    localparam logic [3:0] OP_NOT  = 4'd11;
    localparam logic [3:0] OP_PLUS = 4'd12;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [1:0] ST_SHIFT = 2'd3;

    localparam logic [DataW-1:0] SignBit = {1'b1, {(DataW-1){1'b0}}};

    typedef struct packed {
        logic [3:0]              req_type;
        logic signed [DataW-1:0] operand_a;
        logic                    operand_a_big;
        logic signed [DataW-1:0] operand_b;
        logic                    operand_b_big;
    } t_req;

    typedef struct packed {
        logic signed [DataW-1:0] result_value;
        logic                    result_big;
        logic [1:0]              result_status;
    } t_rsp;

    typedef struct packed {
        logic             valid;
        logic [3:0]       op;
        logic [1:0]       status;
        logic [DataW-1:0] value;
        logic             big;
        logic             q_neg;
        logic             r_neg;
    } t_side;

    typedef struct packed {
        logic [DataW-1:0] rem;
        logic [DataW-1:0] q;
        logic [DataW-1:0] d;
    } t_div_stage;

    // one restoring division step: one quotient bit
    function automatic t_div_stage div_step(input t_div_stage s);
        logic [DataW:0] t;
        t_div_stage     o;
        t = {s.rem, s.q[DataW-1]};
        o = s;
        if (t >= {1'b0, s.d}) begin
            o.rem = DataW'(t - {1'b0, s.d});
            o.q   = {s.q[DataW-2:0], 1'b1};
        end else begin
            o.rem = t[DataW-1:0];
            o.q   = {s.q[DataW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

/* sv/checked_int64_alu.sv */
// Top level of the checked 64-bit integer ALU pipeline.
//
//  channel | valid   | ready   | payload | beat
//  --------+---------+---------+---------+-----------------------------
//  request | i_valid | o_ready | i_data  | opcode, operands, big flags
//  result  | o_valid | i_ready | o_data  | value, big flag, status
//
// One beat per cycle in, one per cycle out while the output is not stalled; the
// pipeline is the decode registers, the 64-stage divider and the output register.
// Reset clears the valid bits of every stage; no state is kept across beats.
// A stall at the output freezes all stages together; bubbles are not squeezed out.
module checked_int64_alu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ci64_pkg::t_req i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ci64_pkg::t_rsp o_data
);
    import ci64_pkg::*;

    t_side            r_side [0:DivStages];
    t_side            n_side0;
    t_side            n_side_mul;
    logic [DataW-1:0] r_mag_a, r_mag_b, n_mag_a, n_mag_b;
    logic             r_out_valid;
    t_rsp             r_out, n_out;
    logic             w_en;

    logic [DataW-1:0] w_mul_val, w_quot, w_rem;
    logic             w_mul_ovf;

    logic [DataW-1:0] w_a, w_b, w_sum, w_diff, w_shl;
    logic [5:0]       w_sh;
    logic             w_any_big;

    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        w_a       = i_data.operand_a;
        w_b       = i_data.operand_b;
        w_sum     = w_a + w_b;
        w_diff    = w_a - w_b;
        w_sh      = w_b[5:0];
        w_shl     = w_a << w_sh;
        w_any_big = i_data.operand_a_big || i_data.operand_b_big;
        n_mag_a   = w_a[DataW-1] ? (~w_a + DataW'(1)) : w_a;
        n_mag_b   = w_b[DataW-1] ? (~w_b + DataW'(1)) : w_b;

        n_side0.valid  = i_valid;
        n_side0.op     = i_data.req_type;
        n_side0.status = ST_OK;
        n_side0.value  = '0;
        n_side0.big    = 1'b0;
        n_side0.q_neg  = w_a[DataW-1] ^ w_b[DataW-1];
        n_side0.r_neg  = w_a[DataW-1];

        if (i_data.req_type <= OP_OR && w_any_big) begin
            n_side0.status = ST_OVF;
        end else begin
            case (i_data.req_type)
                OP_ADD: begin
                    n_side0.value = w_sum;
                    if (w_a[DataW-1] == w_b[DataW-1] && w_sum[DataW-1] != w_a[DataW-1])
                        n_side0.status = ST_OVF;
                end
                OP_SUB: begin
                    n_side0.value = w_diff;
                    if (w_a[DataW-1] != w_b[DataW-1] && w_diff[DataW-1] != w_a[DataW-1])
                        n_side0.status = ST_OVF;
                end
                OP_MUL: ;
                OP_DIV, OP_MOD: begin
                    if (w_b == '0)
                        n_side0.status = ST_DIV0;
                    else if (w_a == SignBit && w_b == '1 && i_data.req_type == OP_DIV)
                        n_side0.status = ST_OVF;
                end
                OP_SHL: begin
                    if (|w_b[DataW-1:6])
                        n_side0.status = ST_SHIFT;
                    else if (($signed(w_shl) >>> w_sh) != $signed(w_a))
                        n_side0.status = ST_OVF;
                    else
                        n_side0.value = w_shl;
                end
                OP_SHR: begin
                    if (|w_b[DataW-1:6])
                        n_side0.status = ST_SHIFT;
                    else
                        n_side0.value = $signed(w_a) >>> w_sh;
                end
                OP_AND: n_side0.value = w_a & w_b;
                OP_XOR: n_side0.value = w_a ^ w_b;
                OP_OR:  n_side0.value = w_a | w_b;
                OP_NEG: begin
                    if (i_data.operand_a_big || w_a == SignBit)
                        n_side0.status = ST_OVF;
                    else
                        n_side0.value = ~w_a + DataW'(1);
                end
                OP_NOT: begin
                    if (i_data.operand_a_big)
                        n_side0.status = ST_OVF;
                    else
                        n_side0.value = ~w_a;
                end
                OP_PLUS: begin
                    n_side0.value = w_a;
                    n_side0.big   = i_data.operand_a_big;
                end
                default: n_side0.status = ST_OVF;
            endcase
        end
    end

    ci64_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_mag_a),
        .i_y   (r_mag_b),
        .i_neg (r_side[0].q_neg),
        .o_val (w_mul_val),
        .o_ovf (w_mul_ovf)
    );

    ci64_div u_div (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_mag_a),
        .i_divisor  (r_mag_b),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_side_mul = r_side[MulStages];
        if (r_side[MulStages].op == OP_MUL && r_side[MulStages].status == ST_OK) begin
            n_side_mul.status = w_mul_ovf ? ST_OVF : ST_OK;
            n_side_mul.value  = w_mul_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DivStages; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_side[0] <= n_side0;
            for (int k = 0; k < DivStages; k++) begin
                if (k == MulStages) begin
                    r_side[k+1] <= n_side_mul;
                end else begin
                    r_side[k+1] <= r_side[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag_a <= n_mag_a;
            r_mag_b <= n_mag_b;
        end
    end

    always_comb begin
        n_out.result_status = r_side[DivStages].status;
        n_out.result_big    = r_side[DivStages].big;
        case (r_side[DivStages].op)
            OP_DIV:  n_out.result_value = r_side[DivStages].q_neg ? (~w_quot + DataW'(1)) : w_quot;
            OP_MOD:  n_out.result_value = r_side[DivStages].r_neg ? (~w_rem + DataW'(1)) : w_rem;
            default: n_out.result_value = r_side[DivStages].value;
        endcase
        if (r_side[DivStages].status != ST_OK) begin
            n_out.result_value = '0;
            n_out.result_big   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_side[DivStages].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_big_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.result_big) |-> (o_data.result_status == ST_OK))
        else $error("big flag set on a failed result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.result_status != ST_OK) |-> (o_data.result_value == '0))
        else $error("nonzero value on a failed result");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_side[DivStages].valid) |=> o_valid)
        else $error("last stage beat not delivered to output");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> ($stable(r_side[DivStages]) && $stable(w_quot)))
        else $error("pipeline moved during stall");

endmodule

/* sv/ci64_mul.sv */
// Three-stage checked multiplier on operand magnitudes.
module ci64_mul (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ci64_pkg::DataW-1:0] i_x,
    input  logic [ci64_pkg::DataW-1:0] i_y,
    input  logic                      i_neg,
    output logic [ci64_pkg::DataW-1:0] o_val,
    output logic                      o_ovf
);
    import ci64_pkg::*;

    logic [DataW-1:0] r_ll, r_lh, r_hl, r_hh;
    logic             r_neg1, r_neg2, r_ovf;
    logic [HalfW+1:0] r_mid;
    logic [DataW-1:0] r_hi_part, r_val;
    logic [HalfW-1:0] r_ll_lo;

    logic [HalfW+1:0] n_mid;
    logic [DataW-1:0] n_hi_part, w_hi, w_lo, n_val;
    logic             n_ovf;

    always_comb begin
        n_mid = (HalfW+2)'(r_ll[DataW-1:HalfW]) + (HalfW+2)'(r_lh[HalfW-1:0])
              + (HalfW+2)'(r_hl[HalfW-1:0]);
        n_hi_part = r_hh + DataW'(r_lh[DataW-1:HalfW]) + DataW'(r_hl[DataW-1:HalfW]);
        w_hi  = r_hi_part + DataW'(r_mid[HalfW+1:HalfW]);
        w_lo  = {r_mid[HalfW-1:0], r_ll_lo};
        n_ovf = (w_hi != '0) || (r_neg2 ? (w_lo > SignBit) : (w_lo >= SignBit));
        n_val = r_neg2 ? (~w_lo + DataW'(1)) : w_lo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll      <= i_x[HalfW-1:0] * i_y[HalfW-1:0];
            r_lh      <= i_x[HalfW-1:0] * i_y[DataW-1:HalfW];
            r_hl      <= i_x[DataW-1:HalfW] * i_y[HalfW-1:0];
            r_hh      <= i_x[DataW-1:HalfW] * i_y[DataW-1:HalfW];
            r_neg1    <= i_neg;
            r_mid     <= n_mid;
            r_hi_part <= n_hi_part;
            r_ll_lo   <= r_ll[HalfW-1:0];
            r_neg2    <= r_neg1;
            r_val     <= n_val;
            r_ovf     <= n_ovf;
        end
    end

    assign o_val = r_val;
    assign o_ovf = r_ovf;

endmodule

/* sv/ci64_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module ci64_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ci64_pkg::DataW-1:0] i_dividend,
    input  logic [ci64_pkg::DataW-1:0] i_divisor,
    output logic [ci64_pkg::DataW-1:0] o_quot,
    output logic [ci64_pkg::DataW-1:0] o_rem
);
    import ci64_pkg::*;

    t_div_stage r_st [0:DivStages-1];
    t_div_stage w_init;

    always_comb begin
        w_init.rem = '0;
        w_init.q   = i_dividend;
        w_init.d   = i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step(w_init);
            for (int k = 1; k < DivStages; k++) begin
                r_st[k] <= div_step(r_st[k-1]);
            end
        end
    end

    assign o_quot = r_st[DivStages-1].q;
    assign o_rem  = r_st[DivStages-1].rem;

endmodule

/* sim/tb.sv */
// Testbench for checked_int64_alu: directed table plus random beats, checked by a predictor.
module tb;
    import ci64_pkg::*;

    localparam logic [63:0] I64_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
    localparam int          LATENCY = 66;
    localparam int          N_RAND  = 1300;
    localparam longint      LIMIT   = 400000;

    typedef struct packed {
        t_req req;
        logic known;
        t_rsp rsp;
    } t_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    t_req   i_data = '0;
    logic   o_valid;
    logic   i_ready = 1'b0;
    t_rsp   o_data;

    t_rsp   pending_rsp[$];
    int     n_bad = 0;
    longint cycle = 0;
    bit     hold_off = 1'b0;
    bit     stim_done = 1'b0;
    t_row   rows[$];

    checked_int64_alu i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_rsp alu_result(input t_req r);
        t_rsp             o;
        logic [63:0]      a;
        logic [63:0]      b;
        logic [127:0]     p;
        logic signed [127:0] sp;
        logic [63:0]      v;
        logic [63:0]      back;
        a = r.operand_a;
        b = r.operand_b;
        o = '0;
        o.result_status = ST_OK;
        v = '0;
        if (r.req_type <= OP_OR && (r.operand_a_big || r.operand_b_big)) begin
            o.result_status = ST_OVF;
        end else begin
            case (r.req_type)
                OP_ADD: begin
                    v = a + b;
                    if (a[63] == b[63] && v[63] != a[63]) o.result_status = ST_OVF;
                end
                OP_SUB: begin
                    v = a - b;
                    if (a[63] != b[63] && v[63] != a[63]) o.result_status = ST_OVF;
                end
                OP_MUL: begin
                    sp = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                    p = sp;
                    v = p[63:0];
                    if (p[127:63] != {65{p[63]}}) o.result_status = ST_OVF;
                end
                OP_DIV, OP_MOD: begin
                    if (b == 0) o.result_status = ST_DIV0;
                    else if (a == I64_MIN && b == '1) begin
                        if (r.req_type == OP_DIV) o.result_status = ST_OVF;
                        else v = '0;
                    end else if (r.req_type == OP_DIV) v = $signed(a) / $signed(b);
                    else v = $signed(a) % $signed(b);
                end
                OP_SHL: begin
                    if (b >= 64) o.result_status = ST_SHIFT;
                    else begin
                        v = a << b[5:0];
                        back = $signed(v) >>> b[5:0];
                        if (back != a) o.result_status = ST_OVF;
                    end
                end
                OP_SHR: begin
                    if (b >= 64) o.result_status = ST_SHIFT;
                    else v = $signed(a) >>> b[5:0];
                end
                OP_AND: v = a & b;
                OP_XOR: v = a ^ b;
                OP_OR:  v = a | b;
                OP_NEG: begin
                    if (r.operand_a_big || a == I64_MIN) o.result_status = ST_OVF;
                    else v = -a;
                end
                OP_NOT: begin
                    if (r.operand_a_big) o.result_status = ST_OVF;
                    else v = ~a;
                end
                OP_PLUS: begin
                    v = a;
                    o.result_big = r.operand_a_big;
                end
                default: o.result_status = ST_OVF;
            endcase
        end
        if (o.result_status != ST_OK) begin
            v = '0;
            o.result_big = 1'b0;
        end
        o.result_value = v;
        return o;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] x;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: x = I64_MAX;
            1: x = I64_MIN;
            2: x = 64'($signed($urandom_range(0, 8)) - 4);
            3: x = 64'($urandom_range(0, 70));
            4: x = {{32{x[31]}}, x[31:0]};
            5: x = $signed(x) >>> $urandom_range(0, 63);
            default: ;
        endcase
        return x;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.req_type      = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(13, 15))
                                                       : 4'($urandom_range(0, 12));
        r.operand_a     = rand_operand();
        r.operand_b     = rand_operand();
        r.operand_a_big = ($urandom_range(0, 11) == 0);
        r.operand_b_big = ($urandom_range(0, 11) == 0);
        return r;
    endfunction

    task automatic add_row(input logic [3:0] op, input logic [63:0] a, input logic ab,
                           input logic [63:0] b, input logic bb, input logic known,
                           input logic [63:0] v, input logic vb, input logic [1:0] st);
        t_row w;
        w.req   = '{op, a, ab, b, bb};
        w.known = known;
        w.rsp   = '{v, vb, st};
        rows.push_back(w);
    endtask

    task automatic send_beat(input t_req r);
        i_valid <= 1'b1;
        i_data  <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // receiver: pattern stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) i_ready <= 1'b0;
        else if ((cycle % 97) < 30) i_ready <= ($urandom_range(0, 3) != 0);
        else if ((cycle % 97) < 60) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 1) != 0);
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        cycle <= cycle + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rsp.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected beat %h", o_data);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_data.result_value !== exp_rsp.result_value ||
                    o_data.result_big !== exp_rsp.result_big ||
                    o_data.result_status !== exp_rsp.result_status) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch exp %h/%b/%0d got %h/%b/%0d",
                                 exp_rsp.result_value, exp_rsp.result_big,
                                 exp_rsp.result_status, o_data.result_value,
                                 o_data.result_big, o_data.result_status);
                end
            end
        end
        if (cycle > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stall_long
        wait (stim_done == 0 && i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        t_req r;
        int   burst;
        add_row(OP_ADD, I64_MAX, 0, 1, 0, 1, 0, 0, ST_OVF);
        add_row(OP_ADD, I64_MIN, 0, '1, 0, 1, 0, 0, ST_OVF);
        add_row(OP_ADD, 5, 1, 1, 0, 1, 0, 0, ST_OVF);
        add_row(OP_SUB, I64_MIN, 0, 1, 0, 1, 0, 0, ST_OVF);
        add_row(OP_SUB, 7, 0, 9, 0, 0, 0, 0, 0);
        add_row(OP_MUL, I64_MIN, 0, 1, 0, 1, I64_MIN, 0, ST_OK);
        add_row(OP_MUL, I64_MIN, 0, '1, 0, 1, 0, 0, ST_OVF);
        add_row(OP_MUL, 64'h1_0000_0000, 0, 64'hffff_ffff_0000_0000, 0, 0, 0, 0, 0);
        add_row(OP_DIV, I64_MIN, 0, '1, 0, 1, 0, 0, ST_OVF);
        add_row(OP_DIV, 5, 0, 0, 0, 1, 0, 0, ST_DIV0);
        add_row(OP_DIV, 5, 0, 0, 1, 1, 0, 0, ST_OVF);
        add_row(OP_DIV, -7, 0, 2, 0, 1, -3, 0, ST_OK);
        add_row(OP_MOD, I64_MIN, 0, '1, 0, 1, 0, 0, ST_OK);
        add_row(OP_MOD, -7, 0, 2, 0, 1, -1, 0, ST_OK);
        add_row(OP_MOD, 3, 0, 0, 0, 1, 0, 0, ST_DIV0);
        add_row(OP_SHL, 1, 0, 64, 0, 1, 0, 0, ST_SHIFT);
        add_row(OP_SHL, 1, 0, '1, 0, 1, 0, 0, ST_SHIFT);
        add_row(OP_SHL, 1, 0, 63, 0, 1, 0, 0, ST_OVF);
        add_row(OP_SHL, '1, 0, 63, 0, 1, I64_MIN, 0, ST_OK);
        add_row(OP_SHR, I64_MIN, 0, 63, 0, 1, '1, 0, ST_OK);
        add_row(OP_AND, '1, 0, I64_MAX, 0, 1, I64_MAX, 0, ST_OK);
        add_row(OP_XOR, '1, 0, I64_MAX, 0, 0, 0, 0, 0);
        add_row(OP_OR, I64_MIN, 0, 1, 0, 0, 0, 0, 0);
        add_row(OP_NEG, I64_MIN, 0, 0, 0, 1, 0, 0, ST_OVF);
        add_row(OP_NOT, 0, 1, 0, 0, 1, 0, 0, ST_OVF);
        add_row(OP_PLUS, I64_MIN, 1, 0, 1, 1, I64_MIN, 1, ST_OK);
        add_row(4'd15, 0, 0, 0, 0, 1, 0, 0, ST_OVF);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            pending_rsp.push_back(rows[k].known ? rows[k].rsp : alu_result(rows[k].req));
            send_beat(rows[k].req);
        end
        i_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(posedge i_clk);

        for (int n = 0; n < N_RAND; ) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && n < N_RAND; j++, n++) begin
                r = rand_req();
                pending_rsp.push_back(alu_result(r));
                send_beat(r);
            end
            i_valid <= 1'b0;
            if (n > 600 && n < 650) begin
                wait (pending_rsp.size() == 0);
                @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
        wait (pending_rsp.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_bad == 0 && pending_rsp.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
